// ===== rtl/ddte_pkg.sv =====
package ddte_pkg;

  localparam int MAX_DIGITS = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [2:0] PREC_NONE   = 3'd0;
  localparam logic [2:0] PREC_YEAR   = 3'd1;
  localparam logic [2:0] PREC_MONTH  = 3'd2;
  localparam logic [2:0] PREC_DAY    = 3'd3;
  localparam logic [2:0] PREC_HOUR   = 3'd4;
  localparam logic [2:0] PREC_MINUTE = 3'd5;
  localparam logic [2:0] PREC_SECOND = 3'd6;

  // one decoded date string, handed from the front to the back
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [2:0]  prec;
  } job_t;

endpackage

// ===== rtl/ddte_front.sv =====
module ddte_front
  import ddte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] character,
  input  logic       last,
  output logic       job_push,
  output job_t       job
);

  logic [3:0] store [MAX_DIGITS];
  logic [3:0] count;
  logic       is_digit;
  logic       wr;
  logic [3:0] new_digit;
  logic [3:0] n_eff;
  logic [3:0] d [MAX_DIGITS];

  assign is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
  assign wr        = accept && is_digit && (count < 4'(MAX_DIGITS));
  assign new_digit = 4'(character - CHAR_ZERO);
  assign n_eff     = count + 4'(wr);

  // the digit taken this cycle counts toward the string it ends
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d[i] = (wr && (count == 4'(i))) ? new_digit : store[i];
    end
  end

  always_comb begin
    job.year   = 14'(d[0]) * 14'd1000 + 14'(d[1]) * 14'd100
               + 14'(d[2]) * 14'd10 + 14'(d[3]);
    job.month  = 7'd1;
    job.day    = 7'd1;
    job.hour   = 7'd0;
    job.minute = 7'd0;
    job.second = 7'd0;
    job.prec   = PREC_NONE;
    if (n_eff >= 4'd4) job.prec = PREC_YEAR;
    if (n_eff >= 4'd6) begin
      job.month = 7'(d[4]) * 7'd10 + 7'(d[5]);
      job.prec  = PREC_MONTH;
    end
    if (n_eff >= 4'd8) begin
      job.day  = 7'(d[6]) * 7'd10 + 7'(d[7]);
      job.prec = PREC_DAY;
    end
    if (n_eff >= 4'd10) begin
      job.hour = 7'(d[8]) * 7'd10 + 7'(d[9]);
      job.prec = PREC_HOUR;
    end
    if (n_eff >= 4'd12) begin
      job.minute = 7'(d[10]) * 7'd10 + 7'(d[11]);
      job.prec   = PREC_MINUTE;
    end
    if (n_eff >= 4'd14) begin
      job.second = 7'(d[12]) * 7'd10 + 7'(d[13]);
      job.prec   = PREC_SECOND;
    end
  end

  assign job_push = accept && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= last ? 4'd0 : n_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      store[count] <= new_digit;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) count <= 4'(MAX_DIGITS))
    else $error("digit count beyond limit");
  assert property (@(posedge clk) disable iff (rst) (accept && last) |=> count == 4'd0)
    else $error("digit count not cleared after last item");
  assert property (@(posedge clk) disable iff (rst)
    (accept && !last && !wr) |=> count == $past(count))
    else $error("digit count moved on a skipped item");
`endif

endmodule

// ===== rtl/ddte_fifo.sv =====
module ddte_fifo
  import ddte_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

// ===== rtl/ddte_back.sv =====
module ddte_back
  import ddte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  job_t               q_data,
  output logic               q_pop,
  output logic signed [38:0] epoch_seconds,
  output logic [2:0]         precision,
  output logic               empty,
  input  logic               pop
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_ERA  = 7'b0000100,
    S_YOE  = 7'b0001000,
    S_DOE  = 7'b0010000,
    S_DAYS = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  job_t   cur;
  logic   res_valid;

  logic signed [14:0] y;
  logic [6:0]         mp;
  logic [18:0]        tod;
  logic signed [5:0]  era;
  logic [13:0]        t;
  logic [8:0]         yoe;
  logic signed [12:0] doy;
  logic signed [19:0] doe;
  logic signed [23:0] era_m;
  logic signed [40:0] prod;

  logic [28:0]        era_prod;
  logic signed [15:0] e400;
  logic signed [15:0] yoe_full;
  logic [27:0]        t_prod;
  logic [17:0]        yoe365;
  logic [14:0]        yoe41;
  logic [17:0]        doe_pos;
  logic signed [40:0] sum;
  logic               res_free;

  // floor(y/400), floor(t/5), floor(yoe/100) by reciprocal multiply
  assign era_prod = 29'(y[13:0]) * 29'd41944;
  assign e400     = 16'(era) * 16'sd400;
  assign yoe_full = 16'(y) - e400;
  assign t_prod   = 28'(t) * 28'd13108;
  assign yoe365   = 18'(yoe) * 18'd365;
  assign yoe41    = 15'(yoe) * 15'd41;
  assign doe_pos  = yoe365 + 18'(yoe[8:2]) - 18'(yoe41[14:12]);
  assign sum      = prod + $signed(41'(tod));

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !res_valid;
  assign res_free = !res_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == S_OUT && res_free) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (!q_empty) state <= S_PREP;
        S_PREP: state <= S_ERA;
        S_ERA:  state <= S_YOE;
        S_YOE:  state <= S_DOE;
        S_DOE:  state <= S_DAYS;
        S_DAYS: state <= S_OUT;
        S_OUT: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (!q_empty) cur <= q_data;
      S_PREP: begin
        // march-based year: january and february belong to the year before
        y   <= $signed(15'(cur.year)) - ((cur.month <= 7'd2) ? 15'sd1 : 15'sd0);
        mp  <= (cur.month > 7'd2) ? cur.month - 7'd3 : cur.month + 7'd9;
        tod <= 19'(cur.hour) * 19'd3600 + 19'(cur.minute) * 19'd60 + 19'(cur.second);
      end
      S_ERA: begin
        era <= y[14] ? -6'sd1 : $signed({1'b0, era_prod[28:24]});
        t   <= 14'(mp) * 14'd153 + 14'd2;
      end
      S_YOE: begin
        yoe <= yoe_full[8:0];
        doy <= $signed(13'(t_prod[27:16])) + $signed(13'(cur.day)) - 13'sd1;
      end
      S_DOE: begin
        doe   <= $signed(20'(doe_pos)) + 20'(doy);
        era_m <= 24'(era) * 24'sd146097;
      end
      S_OUT: begin
        if (res_free) begin
          epoch_seconds <= (cur.prec == PREC_NONE) ? '0 : sum[38:0];
          precision     <= cur.prec;
        end
      end
      default: ;
    endcase
  end

  // days since the epoch scaled to seconds once days are known
  always_ff @(posedge clk) begin
    if (state == S_DAYS) prod <= 41'(era_m + 24'(doe) - 24'sd719468) * 41'sd86400;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && precision == PREC_NONE) |-> epoch_seconds == '0)
    else $error("no precision but nonzero seconds");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !res_free) |=> state == S_OUT)
    else $error("result dropped while output slot busy");
  assert property (@(posedge clk) disable iff (rst) q_pop |=> state == S_PREP)
    else $error("queue popped without starting a conversion");
`endif

endmodule

// ===== rtl/digit_datetime_to_epoch_seconds_top.sv =====
// the item marked last queues a job; back-end states PREP to OUT then set the result
// throughput: one character per cycle while full is low; the sequenced
//   days-from-civil back end takes one job at a time, with a small job queue between
// full rises only when the job queue between front and back is full
// reset (rst, synchronous): clears digit count, queue, sequencer and result flag
module digit_datetime_to_epoch_seconds_top
  import ddte_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         character,
  input  logic               last,
  output logic               empty,
  input  logic               pop,
  output logic signed [38:0] epoch_seconds,
  output logic [2:0]         precision
);

  logic accept;
  logic job_push;
  job_t job;
  logic q_pop;
  logic q_empty;
  job_t q_data;

  assign accept = push && !full;

  ddte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .character (character),
    .last      (last),
    .job_push  (job_push),
    .job       (job)
  );

  ddte_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job),
    .full  (full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  ddte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .epoch_seconds (epoch_seconds),
    .precision     (precision),
    .empty         (empty),
    .pop           (pop)
  );

endmodule
